/* src/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register codes and the configuration record for the
// ellipse color shift core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Screen size defaults
  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 1024;

  // Item field widths
  localparam int COL_W = 10;
  localparam int ROW_W = 10;
  localparam int PIX_W = 32;

  // Register port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Datapath stages ahead of the output register
  localparam int NUM_STAGES = 4;

  // Color channels: 0 blue, 1 green, 2 red
  localparam int NUM_CH = 3;

  // Register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS_X    = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y    = 3'd3;
  localparam logic [2:0] REG_DELTA_RED   = 3'd4;
  localparam logic [2:0] REG_DELTA_GREEN = 3'd5;
  localparam logic [2:0] REG_DELTA_BLUE  = 3'd6;
  localparam logic [2:0] REG_STRENGTH    = 3'd7;

  // x/100 == (x*5243) >> 19 for every x below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic [11:0]        radius_x;
    logic [11:0]        radius_y;
    logic signed [8:0]  delta_red;
    logic signed [8:0]  delta_green;
    logic signed [8:0]  delta_blue;
    logic [6:0]         strength_percent;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_x:         13'sd0,
    center_y:         13'sd0,
    radius_x:         12'd0,
    radius_y:         12'd0,
    delta_red:        9'sd0,
    delta_green:      9'sd0,
    delta_blue:       9'sd0,
    strength_percent: 7'd100
  };

endpackage

`default_nettype wire

/* src/esc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// esc_cfg_regs
// APB-style register file holding the ellipse geometry and color settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::PADDR_W-1:0] paddr,
  input  logic [esc_pkg::PDATA_W-1:0] pwdata,
  output logic [esc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output esc_pkg::cfg_t               cfg
);

  esc_pkg::cfg_t cfg_r;
  esc_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        esc_pkg::REG_CENTER_X:    cfg_nxt.center_x         = pwdata[12:0];
        esc_pkg::REG_CENTER_Y:    cfg_nxt.center_y         = pwdata[12:0];
        esc_pkg::REG_RADIUS_X:    cfg_nxt.radius_x         = pwdata[11:0];
        esc_pkg::REG_RADIUS_Y:    cfg_nxt.radius_y         = pwdata[11:0];
        esc_pkg::REG_DELTA_RED:   cfg_nxt.delta_red        = pwdata[8:0];
        esc_pkg::REG_DELTA_GREEN: cfg_nxt.delta_green      = pwdata[8:0];
        esc_pkg::REG_DELTA_BLUE:  cfg_nxt.delta_blue       = pwdata[8:0];
        esc_pkg::REG_STRENGTH:    cfg_nxt.strength_percent = pwdata[6:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= esc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the stored bits, zero extended
  always_comb begin
    unique case (reg_idx)
      esc_pkg::REG_CENTER_X:    prdata = {19'd0, cfg_r.center_x};
      esc_pkg::REG_CENTER_Y:    prdata = {19'd0, cfg_r.center_y};
      esc_pkg::REG_RADIUS_X:    prdata = {20'd0, cfg_r.radius_x};
      esc_pkg::REG_RADIUS_Y:    prdata = {20'd0, cfg_r.radius_y};
      esc_pkg::REG_DELTA_RED:   prdata = {23'd0, cfg_r.delta_red};
      esc_pkg::REG_DELTA_GREEN: prdata = {23'd0, cfg_r.delta_green};
      esc_pkg::REG_DELTA_BLUE:  prdata = {23'd0, cfg_r.delta_blue};
      esc_pkg::REG_STRENGTH:    prdata = {25'd0, cfg_r.strength_percent};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/esc_cover_pipe.sv */
// ----------------------------------------------------------------------------
// esc_cover_pipe
// Four-stage exact integer ellipse membership test for one pixel per clock while the load enables let it advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_cover_pipe #(
  parameter int SCREEN_WIDTH  = esc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = esc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic [esc_pkg::NUM_STAGES-1:0] ld,
  input  esc_pkg::cfg_t                  cfg,
  input  logic [esc_pkg::COL_W-1:0]      pixel_col,
  input  logic [esc_pkg::ROW_W-1:0]      pixel_row,
  output logic                           hit
);

  localparam logic [12:0] SCR_W = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SCR_H = 13'(SCREEN_HEIGHT);
  // Split point for squaring the 25-bit left side in narrow pieces
  localparam int SPLIT = 13;

  // Stage 1: offsets from the center
  logic signed [13:0] dx, dy;
  logic [12:0] adx_s1_nxt, ady_s1_nxt, adx_s1_r, ady_s1_r;
  logic        ok_s1_nxt, ok_s1_r;

  // Stage 2: range checks and first products
  logic [12:0] odd;
  logic        inr_s2_nxt, inr_s2_r, dz_s2_nxt, dz_s2_r;
  logic [24:0] a_s2_nxt, a_s2_r;
  logic [23:0] rx2_s2_nxt, ry2_s2_nxt, dy2_s2_nxt;
  logic [23:0] rx2_s2_r, ry2_s2_r, dy2_s2_r;

  // Stage 3: partial squares and the row span
  logic [11:0] ah;
  logic [12:0] al;
  logic        inr_s3_r, dz_s3_r;
  logic [23:0] hh_s3_nxt, hh_s3_r;
  logic [24:0] hl_s3_nxt, hl_s3_r;
  logic [25:0] ll_s3_nxt, ll_s3_r;
  logic [23:0] d_s3_nxt, d_s3_r, rx2_s3_r;

  // Stage 4: both sides of the compare
  logic        inr_s4_r, dz_s4_r;
  logic [49:0] lhs_s4_nxt, lhs_s4_r;
  logic [35:0] ph_s4_nxt, pl_s4_nxt, ph_s4_r, pl_s4_r;
  logic [49:0] rhs_sum, rhs;

  always_comb begin
    dx = $signed(14'(pixel_col)) - 14'(cfg.center_x);
    dy = $signed(14'(pixel_row)) - 14'(cfg.center_y);
    adx_s1_nxt = dx[13] ? 13'(-dx) : 13'(dx);
    ady_s1_nxt = dy[13] ? 13'(-dy) : 13'(dy);
    ok_s1_nxt  = (cfg.radius_x != '0) && (cfg.radius_y != '0) &&
                 (13'(pixel_col) < SCR_W) && (13'(pixel_row) < SCR_H);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      adx_s1_r <= adx_s1_nxt;
      ady_s1_r <= ady_s1_nxt;
      ok_s1_r  <= ok_s1_nxt;
    end
  end

  // |dx| beyond radius_x can never round inside, so the products below only
  // need the low 12 bits of each offset.
  always_comb begin
    inr_s2_nxt = ok_s1_r && (ady_s1_r <= 13'(cfg.radius_y)) &&
                 (adx_s1_r <= 13'(cfg.radius_x));
    dz_s2_nxt  = (adx_s1_r == '0);
    odd        = {adx_s1_r[11:0], 1'b0} - 13'd1;
    a_s2_nxt   = 25'(odd) * 25'(cfg.radius_y);
    rx2_s2_nxt = 24'(cfg.radius_x) * 24'(cfg.radius_x);
    ry2_s2_nxt = 24'(cfg.radius_y) * 24'(cfg.radius_y);
    dy2_s2_nxt = 24'(ady_s1_r[11:0]) * 24'(ady_s1_r[11:0]);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      inr_s2_r <= inr_s2_nxt;
      dz_s2_r  <= dz_s2_nxt;
      a_s2_r   <= a_s2_nxt;
      rx2_s2_r <= rx2_s2_nxt;
      ry2_s2_r <= ry2_s2_nxt;
      dy2_s2_r <= dy2_s2_nxt;
    end
  end

  always_comb begin
    ah        = a_s2_r[24:SPLIT];
    al        = a_s2_r[SPLIT-1:0];
    hh_s3_nxt = 24'(ah) * 24'(ah);
    hl_s3_nxt = 25'(ah) * 25'(al);
    ll_s3_nxt = 26'(al) * 26'(al);
    d_s3_nxt  = ry2_s2_r - dy2_s2_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      inr_s3_r <= inr_s2_r;
      dz_s3_r  <= dz_s2_r;
      hh_s3_r  <= hh_s3_nxt;
      hl_s3_r  <= hl_s3_nxt;
      ll_s3_r  <= ll_s3_nxt;
      d_s3_r   <= d_s3_nxt;
      rx2_s3_r <= rx2_s2_r;
    end
  end

  always_comb begin
    lhs_s4_nxt = (50'(hh_s3_r) << (2 * SPLIT)) + (50'(hl_s3_r) << (SPLIT + 1)) +
                 50'(ll_s3_r);
    ph_s4_nxt  = 36'(rx2_s3_r) * 36'(d_s3_r[23:12]);
    pl_s4_nxt  = 36'(rx2_s3_r) * 36'(d_s3_r[11:0]);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      inr_s4_r <= inr_s3_r;
      dz_s4_r  <= dz_s3_r;
      lhs_s4_r <= lhs_s4_nxt;
      ph_s4_r  <= ph_s4_nxt;
      pl_s4_r  <= pl_s4_nxt;
    end
  end

  always_comb begin
    rhs_sum = (50'(ph_s4_r) << 12) + 50'(pl_s4_r);
    rhs     = rhs_sum << 2;
    hit     = inr_s4_r && (dz_s4_r || (lhs_s4_r <= rhs));
  end

endmodule

`default_nettype wire

/* src/esc_color_pipe.sv */
// ----------------------------------------------------------------------------
// esc_color_pipe
// Four-stage per-channel scaled saturating add and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_color_pipe (
  input  logic                           clk,
  input  logic [esc_pkg::NUM_STAGES-1:0] ld,
  input  esc_pkg::cfg_t                  cfg,
  input  logic [esc_pkg::PIX_W-1:0]      pixel_in,
  output logic [esc_pkg::PIX_W-1:0]      pix_orig,
  output logic [esc_pkg::PIX_W-1:0]      pix_shift
);

  localparam int NCH    = esc_pkg::NUM_CH;
  localparam int PROD_W = 28;

  logic signed [8:0]     dlt [NCH];
  logic [8:0]            absd [NCH];
  logic [PROD_W-1:0]     prod [NCH];
  logic [7:0]            amt [NCH];
  logic [7:0]            add_amt [NCH];
  logic [8:0]            sum9 [NCH];
  logic [8:0]            dif9 [NCH];

  logic [NCH-1:0][14:0]  mag_s1_nxt, mag_s1_r;
  logic [NCH-1:0]        neg_s1_nxt, neg_s1_r, neg_s2_r;
  logic [NCH-1:0][8:0]   q_s2_nxt, q_s2_r;
  logic [NCH-1:0][7:0]   ch_s3_nxt, ch_s3_r, sub_s3_nxt, sub_s3_r;
  logic [esc_pkg::PIX_W-1:0] pix_s1_r, pix_s2_r, pix_s3_r, pix_s4_r;
  logic [esc_pkg::PIX_W-1:0] shf_s4_nxt, shf_s4_r;

  assign dlt[0] = cfg.delta_blue;
  assign dlt[1] = cfg.delta_green;
  assign dlt[2] = cfg.delta_red;

  // Stage 1: magnitude of delta times percent
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      neg_s1_nxt[c] = dlt[c][8];
      absd[c]       = dlt[c][8] ? 9'(-dlt[c]) : 9'(dlt[c]);
      mag_s1_nxt[c] = 15'(absd[c]) * 15'(cfg.strength_percent);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mag_s1_r <= mag_s1_nxt;
      neg_s1_r <= neg_s1_nxt;
      pix_s1_r <= pixel_in;
    end
  end

  // Stage 2: divide by 100 through the reciprocal
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c]     = PROD_W'(mag_s1_r[c]) * PROD_W'(esc_pkg::RECIP_100);
      q_s2_nxt[c] = 9'(prod[c] >> esc_pkg::RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      q_s2_r   <= q_s2_nxt;
      neg_s2_r <= neg_s1_r;
      pix_s2_r <= pix_s1_r;
    end
  end

  // Stage 3: clamp the amount, saturating add
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      amt[c]        = q_s2_r[c][8] ? 8'hFF : q_s2_r[c][7:0];
      add_amt[c]    = neg_s2_r[c] ? 8'd0 : amt[c];
      sub_s3_nxt[c] = neg_s2_r[c] ? amt[c] : 8'd0;
      sum9[c]       = 9'(pix_s2_r[8*c +: 8]) + 9'(add_amt[c]);
      ch_s3_nxt[c]  = sum9[c][8] ? 8'hFF : sum9[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ch_s3_r  <= ch_s3_nxt;
      sub_s3_r <= sub_s3_nxt;
      pix_s3_r <= pix_s2_r;
    end
  end

  // Stage 4: saturating subtract, top byte passes
  always_comb begin
    shf_s4_nxt = pix_s3_r;
    for (int c = 0; c < NCH; c++) begin
      dif9[c] = 9'(ch_s3_r[c]) - 9'(sub_s3_r[c]);
      shf_s4_nxt[8*c +: 8] = dif9[c][8] ? 8'd0 : dif9[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      shf_s4_r <= shf_s4_nxt;
      pix_s4_r <= pix_s3_r;
    end
  end

  assign pix_orig  = pix_s4_r;
  assign pix_shift = shf_s4_r;

endmodule

`default_nettype wire

/* src/ellipse_saturating_color_shift_core.sv */
// ----------------------------------------------------------------------------
// ellipse_saturating_color_shift_core
// Streams pixels and shifts the color of those inside a programmable
// axis-aligned ellipse. One item in per clock while in_stall is low, one
// result out per item. Results pass through four datapath stages (offsets,
// first products, partial squares, compare operands) and an output register;
// the exact ellipse test needs a 50-bit square and a 48-bit product, each
// built from narrow multipliers over two stages, and that sets the depth.
// Every stage carries a valid bit and loads when it is empty or the stage
// after it moves, so an out_stall holds only the items that cannot advance
// and bubbles close up; in_stall rises only while out_valid and out_stall
// are both high and every stage is full.
// Program the registers while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ellipse_saturating_color_shift_core #(
  parameter int SCREEN_WIDTH  = esc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = esc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::PADDR_W-1:0] paddr,
  input  logic [esc_pkg::PDATA_W-1:0] pwdata,
  output logic [esc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [esc_pkg::COL_W-1:0]   in_pixel_col,
  input  logic [esc_pkg::ROW_W-1:0]   in_pixel_row,
  input  logic [esc_pkg::PIX_W-1:0]   in_pixel_in,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [esc_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_covered
);

  // Register map (byte addresses, write and read back):
  //   0x00 center_x          13b signed
  //   0x04 center_y          13b signed
  //   0x08 radius_x          12b, zero disables the effect
  //   0x0C radius_y          12b, zero disables the effect
  //   0x10 delta_red          9b signed
  //   0x14 delta_green        9b signed
  //   0x18 delta_blue         9b signed
  //   0x1C strength_percent   7b, reset 100

  localparam int NS = esc_pkg::NUM_STAGES;

  esc_pkg::cfg_t cfg;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS-1:0] ld;
  logic          ld_out;
  logic          out_valid_r, out_valid_nxt;
  logic          hit;
  logic [esc_pkg::PIX_W-1:0] pix_orig, pix_shift;
  logic [esc_pkg::PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic          out_covered_r;

  esc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esc_cover_pipe #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_cover (
    .clk       (clk),
    .ld        (ld),
    .cfg       (cfg),
    .pixel_col (in_pixel_col),
    .pixel_row (in_pixel_row),
    .hit       (hit)
  );

  esc_color_pipe u_color (
    .clk       (clk),
    .ld        (ld),
    .cfg       (cfg),
    .pixel_in  (in_pixel_in),
    .pix_orig  (pix_orig),
    .pix_shift (pix_shift)
  );

  // Load enables ripple back from the output: a stage loads when it holds
  // no item or when the stage after it loads this cycle.
  always_comb begin
    ld_out     = !out_valid_r || !out_stall;
    ld[NS-1]   = !vld_r[NS-1] || ld_out;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_stall = !ld[0];

  // Advance the valid bits alongside the data
  always_comb begin
    vld_nxt[0] = ld[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = ld[i] ? vld_r[i-1] : vld_r[i];
    end
    out_valid_nxt = ld_out ? vld_r[NS-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pick the shifted word only for covered pixels
  assign out_pixel_nxt = hit ? pix_shift : pix_orig;

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_pixel_r   <= out_pixel_nxt;
      out_covered_r <= hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_covered   = out_covered_r;

endmodule

`default_nettype wire

/* src/esc_port_checker.sv */
// ----------------------------------------------------------------------------
// esc_port_checker
// Port-level checks on the ellipse color shift core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [esc_pkg::PIX_W-1:0] in_pixel_in,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [esc_pkg::PIX_W-1:0] out_pixel_out,
  input logic                      out_covered
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
                               $stable(out_covered))
    else $error("stalled result changed");

  // Backpressure only comes from a stalled, full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // With a free output an item reaches the output register; an uncovered one
  // is unchanged and the top byte always passes
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid &&
      (out_pixel_out[31:24] == $past(in_pixel_in[31:24], 5)) &&
      (out_covered || (out_pixel_out == $past(in_pixel_in, 5))))
    else $error("result missing or pass-through bits wrong");

  // Drop all results on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ellipse_saturating_color_shift_core esc_port_checker u_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_pixel_in   (in_pixel_in),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_out (out_pixel_out),
  .out_covered   (out_covered)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ellipse color shift core. Programs the ellipse
// and color registers over the register port, streams pixel items with random
// sender gaps and receiver stalls, and checks every result against an
// in-bench prediction of coverage and saturating channel shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // One pixel item as it goes into the core
  typedef struct {
    logic [esc_pkg::COL_W-1:0] col;
    logic [esc_pkg::ROW_W-1:0] row;
    logic [esc_pkg::PIX_W-1:0] pix;
  } pix_item_t;

  // One predicted result
  typedef struct {
    logic [esc_pkg::PIX_W-1:0] pixel;
    logic                      covered;
  } shaded_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [esc_pkg::PADDR_W-1:0] paddr   = '0;
  logic [esc_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [esc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic [esc_pkg::COL_W-1:0] in_pixel_col = '0;
  logic [esc_pkg::ROW_W-1:0] in_pixel_row = '0;
  logic [esc_pkg::PIX_W-1:0] in_pixel_in  = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [esc_pkg::PIX_W-1:0] out_pixel_out;
  logic                      out_covered;

  pix_item_t     pend_q[$];    // items waiting for the driver
  shaded_t       shaded_q[$];  // predicted results, oldest first
  esc_pkg::cfg_t cur_cfg = esc_pkg::CFG_RESET;

  int issued_cnt = 0;      // items handed to the driver
  int taken_cnt  = 0;      // items accepted by the core
  int errors     = 0;
  logic calm;              // no idling on either side while set

  // Keep a long stretch of back-to-back traffic in the middle of the run
  assign calm = (taken_cnt >= 600) && (taken_cnt < 850);

  ellipse_saturating_color_shift_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_col  (in_pixel_col),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_covered   (out_covered)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Exact integer ellipse test: row within ry, then compare the rounded
  // half-width against |dx| without any square root.
  function automatic bit in_ellipse(input logic [esc_pkg::COL_W-1:0] col,
                                    input logic [esc_pkg::ROW_W-1:0] row);
    longint cx, cy, rx, ry, dx, dy, lhs, rhs;
    cx = longint'($signed(cur_cfg.center_x));
    cy = longint'($signed(cur_cfg.center_y));
    rx = longint'(cur_cfg.radius_x);
    ry = longint'(cur_cfg.radius_y);
    if (rx < 1 || ry < 1) return 1'b0;
    if (longint'(col) >= esc_pkg::SCREEN_WIDTH_DEF ||
        longint'(row) >= esc_pkg::SCREEN_HEIGHT_DEF)
      return 1'b0;
    dy = longint'(row) - cy;
    if (dy < 0) dy = -dy;
    if (dy > ry) return 1'b0;
    dx = longint'(col) - cx;
    if (dx < 0) dx = -dx;
    if (dx == 0) return 1'b1;
    lhs = (2 * dx - 1) * ry;
    lhs = lhs * lhs;
    rhs = 4 * rx * rx * (ry * ry - dy * dy);
    return lhs <= rhs;
  endfunction

  // Scale the delta, then saturating add followed by saturating subtract
  function automatic logic [7:0] sat_shift(input logic [7:0] c,
                                           input logic signed [8:0] d,
                                           input logic [6:0] pct);
    int v, add, sub, r;
    v   = (int'(d) * int'(pct)) / 100;  // truncates toward zero
    add = (v < 0) ? 0 : ((v > 255) ? 255 : v);
    sub = (-v < 0) ? 0 : ((-v > 255) ? 255 : -v);
    r   = int'(c) + add;
    if (r > 255) r = 255;
    r = r - sub;
    if (r < 0) r = 0;
    return r[7:0];
  endfunction

  function automatic shaded_t shade_pixel(input logic [esc_pkg::COL_W-1:0] col,
                                          input logic [esc_pkg::ROW_W-1:0] row,
                                          input logic [esc_pkg::PIX_W-1:0] pix);
    shaded_t s;
    s.pixel   = pix;
    s.covered = 1'b0;
    if (in_ellipse(col, row)) begin
      s.pixel[23:16] = sat_shift(pix[23:16], cur_cfg.delta_red, cur_cfg.strength_percent);
      s.pixel[15:8]  = sat_shift(pix[15:8], cur_cfg.delta_green, cur_cfg.strength_percent);
      s.pixel[7:0]   = sat_shift(pix[7:0], cur_cfg.delta_blue, cur_cfg.strength_percent);
      s.covered      = 1'b1;
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on acceptance, advance to the next pending item when the
  // slot is free, idle at random except in the calm window.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    pix_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // Inputs still hold the accepted item here; NBAs are not applied yet
        shaded_q.push_back(shade_pixel(in_pixel_col, in_pixel_row, in_pixel_in));
        taken_cnt++;
      end
      // Hold the payload while stalled; otherwise load or drop valid
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          it = pend_q.pop_front();
          in_valid     <= 1'b1;
          in_pixel_col <= it.col;
          in_pixel_row <= it.row;
          in_pixel_in  <= it.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, then
  // pick the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    shaded_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shaded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got pixel_out %08h covered %0d",
                   $realtime, out_pixel_out, out_covered);
        end else begin
          want = shaded_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %08h, got %08h",
                     $realtime, want.pixel, out_pixel_out);
          end
          if (out_covered !== want.covered) begin
            errors++;
            $display("%0t: covered expected %0d, got %0d",
                     $realtime, want.covered, out_covered);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [2:0] idx,
                           input logic [esc_pkg::PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      esc_pkg::REG_CENTER_X:    cur_cfg.center_x         = val[12:0];
      esc_pkg::REG_CENTER_Y:    cur_cfg.center_y         = val[12:0];
      esc_pkg::REG_RADIUS_X:    cur_cfg.radius_x         = val[11:0];
      esc_pkg::REG_RADIUS_Y:    cur_cfg.radius_y         = val[11:0];
      esc_pkg::REG_DELTA_RED:   cur_cfg.delta_red        = val[8:0];
      esc_pkg::REG_DELTA_GREEN: cur_cfg.delta_green      = val[8:0];
      esc_pkg::REG_DELTA_BLUE:  cur_cfg.delta_blue       = val[8:0];
      esc_pkg::REG_STRENGTH:    cur_cfg.strength_percent = val[6:0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(input int cx, input int cy, input int rx, input int ry,
                             input int dr, input int dg, input int db, input int pct);
    logic [31:0] w;
    w = cx;  cfg_write(esc_pkg::REG_CENTER_X,    {19'd0, w[12:0]});
    w = cy;  cfg_write(esc_pkg::REG_CENTER_Y,    {19'd0, w[12:0]});
    w = rx;  cfg_write(esc_pkg::REG_RADIUS_X,    {20'd0, w[11:0]});
    w = ry;  cfg_write(esc_pkg::REG_RADIUS_Y,    {20'd0, w[11:0]});
    w = dr;  cfg_write(esc_pkg::REG_DELTA_RED,   {23'd0, w[8:0]});
    w = dg;  cfg_write(esc_pkg::REG_DELTA_GREEN, {23'd0, w[8:0]});
    w = db;  cfg_write(esc_pkg::REG_DELTA_BLUE,  {23'd0, w[8:0]});
    w = pct; cfg_write(esc_pkg::REG_STRENGTH,    {25'd0, w[6:0]});
  endtask

  task automatic push_item(input int col, input int row, input logic [31:0] pix);
    pix_item_t it;
    it.col = col[esc_pkg::COL_W-1:0];
    it.row = row[esc_pkg::ROW_W-1:0];
    it.pix = pix;
    pend_q.push_back(it);
    issued_cnt++;
  endtask

  // Wait until every issued item is accepted and every result has come back
  task automatic drain();
    while (taken_cnt != issued_cnt || shaded_q.size() != 0) @(posedge clk);
  endtask

  // Coordinate near the ellipse span, or anywhere when that falls off screen
  function automatic int near_coord(input int center, input int radius);
    int span, v;
    span = radius + 2;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0 || v > 1023) v = int'($urandom_range(0, 1023));
    return v;
  endfunction

  function automatic int pick_radius();
    int sel;
    sel = int'($urandom_range(0, 9));
    case (sel)
      0:       return 0;
      1:       return 1;
      2:       return 4095;
      default: return int'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    logic [31:0] p;
    p = $urandom;
    // Push channels to the rails now and then to hit both saturations
    if ($urandom_range(0, 9) == 0) begin
      p[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic random_phase(input int n_items);
    int cx, cy, rx, ry, pct, k;
    if ($urandom_range(0, 4) == 0) begin
      cx = int'($urandom_range(0, 8191)) - 4096;
      cy = int'($urandom_range(0, 8191)) - 4096;
    end else begin
      cx = int'($urandom_range(0, 1151)) - 64;
      cy = int'($urandom_range(0, 1151)) - 64;
    end
    rx  = pick_radius();
    ry  = pick_radius();
    pct = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 100))
                                       : int'($urandom_range(101, 127));
    program_cfg(cx, cy, rx, ry,
                int'($urandom_range(0, 511)) - 256,
                int'($urandom_range(0, 511)) - 256,
                int'($urandom_range(0, 511)) - 256, pct);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 85)
        push_item(near_coord(cx, rx), near_coord(cy, ry), pick_pixel());
      else
        push_item(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)), $urandom);
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: both radii zero, so everything passes through
    push_item(0, 0, 32'h0000_0000);
    push_item(1023, 1023, 32'hFFFF_FFFF);
    push_item(0, 1023, 32'hA5A5_A5A5);
    push_item(1023, 0, 32'h5A5A_5A5A);
    drain();

    // Small ellipse, full-scale deltas including -256, strength above 100
    program_cfg(100, 100, 50, 30, 255, -255, -256, 127);
    push_item(100, 100, 32'h1234_5678);
    push_item(150, 100, 32'h80FF_0080);
    push_item(151, 100, 32'h0000_0000);
    push_item(100, 130, 32'hFF7F_7F7F);
    push_item(100, 131, 32'h0102_0304);
    push_item(50, 100, 32'hDEAD_BEEF);
    push_item(135, 121, 32'hC0C0_C0C0);
    push_item(100, 70, 32'h00FF_FFFF);
    drain();

    // Center at the negative corner, largest radii, zero strength
    program_cfg(-4096, -4096, 4095, 4095, -1, 1, 0, 0);
    push_item(0, 0, 32'hFFFF_FFFF);
    push_item(1023, 1023, 32'h0000_0000);
    drain();

    // Center at the positive corner, largest radii
    program_cfg(4095, 4095, 4095, 4095, 100, -100, 37, 100);
    push_item(1023, 1023, 32'h7F80_FF00);
    push_item(0, 0, 32'h0001_FE7F);
    push_item(1023, 0, 32'hFFFF_FFFF);
    drain();

    // Unit radii: only the center and its four neighbors can be covered
    program_cfg(512, 512, 1, 1, 255, 255, 255, 1);
    push_item(512, 512, 32'hFF00_0000);
    push_item(513, 512, 32'hFFFF_FFFF);
    push_item(512, 513, 32'h0080_80FE);
    push_item(513, 513, 32'h0000_0000);
    push_item(511, 511, 32'h1111_1111);
    push_item(514, 512, 32'h2222_2222);
    drain();

    for (p = 0; p < 14; p++) random_phase(100);

    // Give any stray result time to show up
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* ellipse_saturating_color_shift_core.f */
src/esc_pkg.sv
src/esc_cfg_regs.sv
src/esc_cover_pipe.sv
src/esc_color_pipe.sv
src/ellipse_saturating_color_shift_core.sv
src/esc_port_checker.sv
tb/tb.sv
